// ===== design/nfa_pkg.sv =====
// ----------------------------------------------------------------------------
// nfa_pkg
// Shared widths, codes and types of the bit-parallel NFA acceptor.
// ----------------------------------------------------------------------------
package nfa_pkg;

    localparam int SET_W     = 32;
    localparam int STATE_W   = 5;
    localparam int SYM_W     = 4;
    localparam int CMD_W     = 2;
    localparam int COUNT_W   = 16;
    localparam int CFG_IDX_W = 2;
    localparam int SYMCNT_W  = 5;

    localparam logic [SYMCNT_W-1:0] SYMBOL_COUNT_RST = 5'd16;
    localparam logic                POLARITY_RST     = 1'b1;

    typedef logic [SET_W-1:0] t_set;

    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD   = 2'd0,
        CMD_SYMBOL = 2'd1,
        CMD_EMPTY  = 2'd2,
        CMD_CLEAR  = 2'd3
    } t_cmd;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SYMBOL_COUNT    = 2'd0,
        CFG_INITIAL_SET     = 2'd1,
        CFG_FINAL_SET       = 2'd2,
        CFG_ACCEPT_POLARITY = 2'd3
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_WAVE,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic             en;
        logic [SYM_W-1:0] addr;
        t_set             data;
    } t_row_wr;

endpackage

// ===== design/nfa_cell.sv =====
// ----------------------------------------------------------------------------
// nfa_cell
// One automaton state: its successor rows and one stage of the OR chain.
// ----------------------------------------------------------------------------
module nfa_cell #(
    parameter int ROWS = 16
) (
    input  logic                    i_clk,
    input  nfa_pkg::t_row_wr        i_wr,
    input  logic [$clog2(ROWS)-1:0] i_rd_addr,
    input  logic                    i_active,
    input  nfa_pkg::t_set           i_acc,
    output nfa_pkg::t_set           o_acc
);

    localparam int ROW_AW = $clog2(ROWS);

    nfa_pkg::t_set r_mem [ROWS];
    nfa_pkg::t_set r_rd;
    nfa_pkg::t_set r_acc;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr[ROW_AW-1:0]] <= i_wr.data;
        end
        r_rd <= r_mem[i_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        r_acc <= i_acc | (i_active ? r_rd : '0);
    end

    assign o_acc = r_acc;

endmodule

// ===== design/nfa_bitset_acceptor.sv =====
// A sample symbol holds off further input until the OR wave, which moves one cell per
// cycle down the chain of min(NUM_STATES, 32) cells, has passed through READ and WAVE.
// A last symbol then passes through DONE, where the result waits for the output to be
// free; an empty sample goes straight to DONE. Row loads and count clears are taken in IDLE.
// Reset: a clearing pass zeroes all min(NUM_SYMBOLS, 16) rows of every cell, input not ready.
// ----------------------------------------------------------------------------
// nfa_bitset_acceptor
// Bit-parallel NFA simulation over a chain of per-state cells with match count.
// ----------------------------------------------------------------------------
module nfa_bitset_acceptor #(
    parameter int NUM_STATES  = 32,
    parameter int NUM_SYMBOLS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,

    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [nfa_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [nfa_pkg::SET_W-1:0]     i_cfg_data,

    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [nfa_pkg::CMD_W-1:0]     i_command,
    input  logic [nfa_pkg::STATE_W-1:0]   i_from_state,
    input  logic [nfa_pkg::SYM_W-1:0]     i_symbol,
    input  logic [nfa_pkg::SET_W-1:0]     i_successor_set,
    input  logic                          i_last,

    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic                          o_accepted,
    output logic                          o_matched,
    output logic [nfa_pkg::COUNT_W-1:0]   o_match_count,
    output logic [nfa_pkg::SET_W-1:0]     o_active_states
);

    localparam int CELLS  = (NUM_STATES < nfa_pkg::SET_W) ? NUM_STATES : nfa_pkg::SET_W;
    localparam int ROWS   = (NUM_SYMBOLS < (2 ** nfa_pkg::SYM_W)) ?
                            NUM_SYMBOLS : (2 ** nfa_pkg::SYM_W);
    localparam int ROW_AW = $clog2(ROWS);
    localparam int CNT_W  = $clog2(CELLS + 1);
    localparam nfa_pkg::t_set STATE_MASK = (CELLS >= nfa_pkg::SET_W) ? '1 :
                                           nfa_pkg::SET_W'((64'd1 << CELLS) - 64'd1);
    localparam logic [nfa_pkg::COUNT_W-1:0] COUNT_MAX = '1;

    nfa_pkg::t_state r_state;
    nfa_pkg::t_state n_state;
    nfa_pkg::t_cmd   w_cmd;

    logic [nfa_pkg::SYMCNT_W-1:0] r_symbol_count;
    nfa_pkg::t_set                r_initial;
    nfa_pkg::t_set                r_final;
    logic                         r_polarity;

    nfa_pkg::t_set                r_active;
    logic                         r_in_sample;
    logic [ROW_AW-1:0]            r_row;
    logic                         r_sym_ok;
    logic                         r_last;
    logic [CNT_W-1:0]             r_cnt;
    logic [ROW_AW-1:0]            r_clr;
    logic [nfa_pkg::COUNT_W-1:0]  r_count;

    logic                         r_out_valid;
    logic                         r_accepted;
    logic                         r_matched;
    logic [nfa_pkg::COUNT_W-1:0]  r_out_count;
    nfa_pkg::t_set                r_out_set;

    logic                         w_accept_in;
    logic                         w_out_free;
    logic                         w_wave_end;
    logic                         w_finish;
    logic                         w_row_ok;
    logic                         w_sym_ok;
    logic                         w_hit;
    logic                         w_match;
    logic [nfa_pkg::COUNT_W-1:0]  w_count_next;
    nfa_pkg::t_row_wr             w_wr;
    nfa_pkg::t_row_wr             w_cell_wr [CELLS];
    nfa_pkg::t_set                w_acc [CELLS+1];

    assign w_cmd       = nfa_pkg::t_cmd'(i_command);
    assign w_accept_in = i_in_valid && o_in_ready;
    assign w_out_free  = !r_out_valid || i_out_ready;
    assign w_wave_end  = (r_state == nfa_pkg::ST_WAVE) && (r_cnt == CNT_W'(CELLS));
    assign w_row_ok    = ({1'b0, i_symbol} < nfa_pkg::SYMCNT_W'(ROWS));
    assign w_sym_ok    = w_row_ok && ({1'b0, i_symbol} < r_symbol_count);
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= nfa_pkg::ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        w_finish   = 1'b0;
        case (r_state)
            nfa_pkg::ST_CLEAR: begin
                if (r_clr == ROW_AW'(ROWS - 1)) begin
                    n_state = nfa_pkg::ST_IDLE;
                end
            end
            nfa_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    case (w_cmd)
                        nfa_pkg::CMD_SYMBOL: n_state = nfa_pkg::ST_READ;
                        nfa_pkg::CMD_EMPTY:  n_state = nfa_pkg::ST_DONE;
                        default:             n_state = nfa_pkg::ST_IDLE;
                    endcase
                end
            end
            nfa_pkg::ST_READ: begin
                n_state = nfa_pkg::ST_WAVE;
            end
            nfa_pkg::ST_WAVE: begin
                if (w_wave_end) begin
                    n_state = r_last ? nfa_pkg::ST_DONE : nfa_pkg::ST_IDLE;
                end
            end
            nfa_pkg::ST_DONE: begin
                if (w_out_free) begin
                    w_finish = 1'b1;
                    n_state  = nfa_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = nfa_pkg::ST_CLEAR;
            end
        endcase
    end

    // cell write port: clearing sweep or row load
    always_comb begin
        if (r_state == nfa_pkg::ST_CLEAR) begin
            w_wr.en   = 1'b1;
            w_wr.addr = nfa_pkg::SYM_W'(r_clr);
            w_wr.data = '0;
        end else begin
            w_wr.en   = w_accept_in && (w_cmd == nfa_pkg::CMD_LOAD) && w_row_ok;
            w_wr.addr = i_symbol;
            w_wr.data = i_successor_set & STATE_MASK;
        end
    end

    assign w_acc[0] = '0;

    for (genvar k = 0; k < CELLS; k++) begin : g_cell
        assign w_cell_wr[k] = nfa_pkg::t_row_wr'{
            en:   w_wr.en && ((r_state == nfa_pkg::ST_CLEAR) ||
                              (i_from_state == nfa_pkg::STATE_W'(k))),
            addr: w_wr.addr,
            data: w_wr.data
        };

        nfa_cell #(
            .ROWS (ROWS)
        ) u_cell (
            .i_clk     (i_clk),
            .i_wr      (w_cell_wr[k]),
            .i_rd_addr (r_row),
            .i_active  (r_active[k]),
            .i_acc     (w_acc[k]),
            .o_acc     (w_acc[k+1])
        );
    end

    assign w_hit        = |(r_active & r_final);
    assign w_match      = (w_hit == r_polarity);
    assign w_count_next = (w_match && (r_count != COUNT_MAX)) ?
                          r_count + nfa_pkg::COUNT_W'(1) : r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_symbol_count <= nfa_pkg::SYMBOL_COUNT_RST;
            r_initial      <= '0;
            r_final        <= '0;
            r_polarity     <= nfa_pkg::POLARITY_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (nfa_pkg::t_cfg_idx'(i_cfg_index))
                nfa_pkg::CFG_SYMBOL_COUNT:    r_symbol_count <= i_cfg_data[nfa_pkg::SYMCNT_W-1:0];
                nfa_pkg::CFG_INITIAL_SET:     r_initial      <= i_cfg_data;
                nfa_pkg::CFG_FINAL_SET:       r_final        <= i_cfg_data;
                nfa_pkg::CFG_ACCEPT_POLARITY: r_polarity     <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr       <= '0;
            r_cnt       <= '0;
            r_active    <= '0;
            r_in_sample <= 1'b0;
            r_count     <= '0;
        end else begin
            if (r_state == nfa_pkg::ST_CLEAR) begin
                r_clr <= r_clr + ROW_AW'(1);
            end
            if (r_state == nfa_pkg::ST_READ) begin
                r_cnt <= '0;
            end else if (r_state == nfa_pkg::ST_WAVE) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end
            if (w_accept_in) begin
                case (w_cmd)
                    nfa_pkg::CMD_SYMBOL: begin
                        if (!r_in_sample) begin
                            r_active <= r_initial & STATE_MASK;
                        end
                        r_in_sample <= 1'b1;
                    end
                    nfa_pkg::CMD_EMPTY: begin
                        r_active    <= r_initial & STATE_MASK;
                        r_in_sample <= 1'b0;
                    end
                    nfa_pkg::CMD_CLEAR: begin
                        r_count <= '0;
                    end
                    default: ;
                endcase
            end
            if (w_wave_end) begin
                r_active <= r_sym_ok ? w_acc[CELLS] : '0;
                if (r_last) begin
                    r_in_sample <= 1'b0;
                end
            end
            if (w_finish) begin
                r_count <= w_count_next;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept_in && (w_cmd == nfa_pkg::CMD_SYMBOL)) begin
            r_row    <= w_sym_ok ? i_symbol[ROW_AW-1:0] : '0;
            r_sym_ok <= w_sym_ok;
            r_last   <= i_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_finish) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_finish) begin
            r_accepted  <= w_hit;
            r_matched   <= w_match;
            r_out_count <= w_count_next;
            r_out_set   <= r_active;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_accepted      = r_accepted;
    assign o_matched       = r_matched;
    assign o_match_count   = r_out_count;
    assign o_active_states = r_out_set;

`ifndef NO_ASSERTIONS
    a_symbol_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept_in && (w_cmd == nfa_pkg::CMD_SYMBOL)) |=> !o_in_ready)
        else $error("input ready right after a symbol transfer");

    a_out_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state == nfa_pkg::ST_DONE))
        else $error("result raised outside finish");

    a_wave_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == nfa_pkg::ST_WAVE) |-> ($stable(r_row) && $stable(r_active)))
        else $error("row address or active set moved during wave");

    a_count_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_count == COUNT_MAX) && !(w_accept_in && (w_cmd == nfa_pkg::CMD_CLEAR)))
        |=> (r_count == COUNT_MAX))
        else $error("match count left saturation without clear");
`endif

endmodule

// ===== tb/sv/nfa_bitset_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// nfa_bitset_checker
// Watches the config, input and result channels of the NFA acceptor. Keeps its
// own successor table, active set, match count and register copies. Checks every
// result transfer field by field against the oldest predicted sample verdict.
// ----------------------------------------------------------------------------
module nfa_bitset_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,

    input  logic                          i_cfg_valid,
    input  logic                          i_cfg_ready,
    input  logic [nfa_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [nfa_pkg::SET_W-1:0]     i_cfg_data,

    input  logic                          i_in_valid,
    input  logic                          i_in_ready,
    input  logic [nfa_pkg::CMD_W-1:0]     i_command,
    input  logic [nfa_pkg::STATE_W-1:0]   i_from_state,
    input  logic [nfa_pkg::SYM_W-1:0]     i_symbol,
    input  logic [nfa_pkg::SET_W-1:0]     i_successor_set,
    input  logic                          i_last,

    input  logic                          i_out_valid,
    input  logic                          i_out_ready,
    input  logic                          i_accepted,
    input  logic                          i_matched,
    input  logic [nfa_pkg::COUNT_W-1:0]   i_match_count,
    input  logic [nfa_pkg::SET_W-1:0]     i_active_states,

    output int                            o_fail_count,
    output int                            o_pending
);

    localparam int ROWS = 1 << (nfa_pkg::STATE_W + nfa_pkg::SYM_W);

    typedef struct packed {
        logic                        accepted;
        logic                        matched;
        logic [nfa_pkg::COUNT_W-1:0] match_count;
        nfa_pkg::t_set               active_states;
    } t_verdict;

    t_verdict                     verdicts_due[$];
    nfa_pkg::t_set                succ_rows [0:ROWS-1];
    nfa_pkg::t_set                live_states;
    logic                         in_sample;
    logic [nfa_pkg::COUNT_W-1:0]  match_total;

    logic [nfa_pkg::SYMCNT_W-1:0] sym_limit;
    nfa_pkg::t_set                init_mask;
    nfa_pkg::t_set                final_mask;
    logic                         polarity;

    function automatic void flag_field(input string field,
                                       input logic [nfa_pkg::SET_W-1:0] want,
                                       input logic [nfa_pkg::SET_W-1:0] got);
        if (want !== got) begin
            o_fail_count++;
            $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
        end
    endfunction

    function automatic nfa_pkg::t_set advance_set(input nfa_pkg::t_set cur,
                                                  input logic [nfa_pkg::SYM_W-1:0] sym);
        nfa_pkg::t_set nxt;
        nxt = '0;
        if ({1'b0, sym} < sym_limit) begin
            for (int s = 0; s < nfa_pkg::SET_W; s++) begin
                if (cur[s])
                    nxt |= succ_rows[(s << nfa_pkg::SYM_W) | int'(sym)];
            end
        end
        return nxt;
    endfunction

    function automatic void close_sample(input nfa_pkg::t_set end_states);
        t_verdict v;
        v.accepted = |(end_states & final_mask);
        v.matched  = (v.accepted == polarity);
        if (v.matched && match_total != '1)
            match_total++;
        v.match_count   = match_total;
        v.active_states = end_states;
        verdicts_due.push_back(v);
    endfunction

    always @(posedge i_clk) begin
        t_verdict want;
        if (!i_rst_n) begin
            for (int i = 0; i < ROWS; i++)
                succ_rows[i] = '0;
            live_states  = '0;
            in_sample    = 1'b0;
            match_total  = '0;
            sym_limit    = nfa_pkg::SYMBOL_COUNT_RST;
            init_mask    = '0;
            final_mask   = '0;
            polarity     = nfa_pkg::POLARITY_RST;
            o_fail_count = 0;
            verdicts_due.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (verdicts_due.size() == 0) begin
                    o_fail_count++;
                    $error("result transfer with no finished sample awaiting it");
                end else begin
                    want = verdicts_due.pop_front();
                    flag_field("accepted", nfa_pkg::SET_W'(want.accepted),
                               nfa_pkg::SET_W'(i_accepted));
                    flag_field("matched", nfa_pkg::SET_W'(want.matched),
                               nfa_pkg::SET_W'(i_matched));
                    flag_field("match_count", nfa_pkg::SET_W'(want.match_count),
                               nfa_pkg::SET_W'(i_match_count));
                    flag_field("active_states", want.active_states, i_active_states);
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                case (nfa_pkg::t_cfg_idx'(i_cfg_index))
                    nfa_pkg::CFG_SYMBOL_COUNT:    sym_limit  = i_cfg_data[nfa_pkg::SYMCNT_W-1:0];
                    nfa_pkg::CFG_INITIAL_SET:     init_mask  = i_cfg_data;
                    nfa_pkg::CFG_FINAL_SET:       final_mask = i_cfg_data;
                    nfa_pkg::CFG_ACCEPT_POLARITY: polarity   = i_cfg_data[0];
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready) begin
                case (nfa_pkg::t_cmd'(i_command))
                    nfa_pkg::CMD_LOAD: begin
                        succ_rows[{i_from_state, i_symbol}] = i_successor_set;
                    end
                    nfa_pkg::CMD_SYMBOL: begin
                        if (!in_sample) begin
                            live_states = init_mask;
                            in_sample   = 1'b1;
                        end
                        live_states = advance_set(live_states, i_symbol);
                        if (i_last) begin
                            in_sample = 1'b0;
                            close_sample(live_states);
                        end
                    end
                    nfa_pkg::CMD_EMPTY: begin
                        in_sample   = 1'b0;
                        live_states = init_mask;
                        close_sample(live_states);
                    end
                    default: begin
                        match_total = '0;
                    end
                endcase
            end
        end
        o_pending = verdicts_due.size();
    end

endmodule

// ===== tb/sv/nfa_bitset_acceptor_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// nfa_bitset_acceptor_tb
// Drives row loads, sample symbols, empty samples and count clears into the NFA
// acceptor: a directed pass over the corner cases, then random automata and
// samples under several register settings. A checker beside the block predicts
// and compares every result.
// ----------------------------------------------------------------------------
module nfa_bitset_acceptor_tb;

    localparam int HOLD_OFF      = 40;
    localparam int STALL_LIMIT   = 5000;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_ITEMS   = 166;

    logic                          i_clk;
    logic                          i_rst_n         = 1'b0;
    logic                          i_cfg_valid     = 1'b0;
    logic                          o_cfg_ready;
    logic [nfa_pkg::CFG_IDX_W-1:0] i_cfg_index     = '0;
    nfa_pkg::t_set                 i_cfg_data      = '0;
    logic                          i_in_valid      = 1'b0;
    logic                          o_in_ready;
    logic [nfa_pkg::CMD_W-1:0]     i_command       = '0;
    logic [nfa_pkg::STATE_W-1:0]   i_from_state    = '0;
    logic [nfa_pkg::SYM_W-1:0]     i_symbol        = '0;
    nfa_pkg::t_set                 i_successor_set = '0;
    logic                          i_last          = 1'b0;
    logic                          o_out_valid;
    logic                          i_out_ready     = 1'b0;
    logic                          o_accepted;
    logic                          o_matched;
    logic [nfa_pkg::COUNT_W-1:0]   o_match_count;
    nfa_pkg::t_set                 o_active_states;

    int                            n_fails;
    int                            n_pending;
    int unsigned                   n_items       = 0;
    int unsigned                   burst_left    = 0;
    logic [nfa_pkg::SYMCNT_W-1:0]  cur_sym_count = nfa_pkg::SYMBOL_COUNT_RST;
    logic [9:0]                    rx_phase      = '0;
    int unsigned                   rx_stall      = 0;

    nfa_bitset_acceptor u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_command       (i_command),
        .i_from_state    (i_from_state),
        .i_symbol        (i_symbol),
        .i_successor_set (i_successor_set),
        .i_last          (i_last),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_accepted      (o_accepted),
        .o_matched       (o_matched),
        .o_match_count   (o_match_count),
        .o_active_states (o_active_states)
    );

    nfa_bitset_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .i_in_ready      (o_in_ready),
        .i_command       (i_command),
        .i_from_state    (i_from_state),
        .i_symbol        (i_symbol),
        .i_successor_set (i_successor_set),
        .i_last          (i_last),
        .i_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .i_accepted      (o_accepted),
        .i_matched       (o_matched),
        .i_match_count   (o_match_count),
        .i_active_states (o_active_states),
        .o_fail_count    (n_fails),
        .o_pending       (n_pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Result side: stall-free window whenever rx_phase[9:8] is zero, random stalls elsewhere.
    always @(negedge i_clk) begin
        rx_phase <= rx_phase + 1'b1;
        if (rx_phase[9:8] == 2'd0) begin
            i_out_ready <= 1'b1;
            rx_stall    <= 0;
        end else if (rx_stall != 0) begin
            i_out_ready <= 1'b0;
            rx_stall    <= rx_stall - 1;
        end else if ($urandom_range(0, 7) == 0) begin
            i_out_ready <= 1'b0;
            rx_stall    <= $urandom_range(0, 15);
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    initial begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
                (i_cfg_valid && o_cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("FAILURE");
        $finish;
    end

    function automatic nfa_pkg::t_set pick_set();
        nfa_pkg::t_set s;
        case ($urandom_range(0, 9))
            0:       s = '0;
            1:       s = '1;
            2, 3:    s = $urandom();
            default: begin
                s = '0;
                repeat ($urandom_range(1, 3))
                    s[$urandom_range(0, ($urandom_range(0, 1) != 0) ? 7 : 31)] = 1'b1;
            end
        endcase
        return s;
    endfunction

    function automatic logic [nfa_pkg::SYM_W-1:0] pick_sym();
        if ($urandom_range(0, 6) != 0)
            return nfa_pkg::SYM_W'($urandom_range(0, int'(cur_sym_count) - 1));
        return nfa_pkg::SYM_W'($urandom_range(0, 15));
    endfunction

    function automatic logic [nfa_pkg::STATE_W-1:0] pick_state();
        return nfa_pkg::STATE_W'(($urandom_range(0, 1) != 0) ? $urandom_range(0, 7) :
                                                               $urandom_range(0, 31));
    endfunction

    task automatic send_item(input nfa_pkg::t_cmd cmd,
                             input logic [nfa_pkg::STATE_W-1:0] from,
                             input logic [nfa_pkg::SYM_W-1:0] sym, input nfa_pkg::t_set succ,
                             input logic last);
        int unsigned gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap != 0) begin
                @(negedge i_clk);
                i_in_valid = 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
        end
        burst_left--;
        @(negedge i_clk);
        i_in_valid      = 1'b1;
        i_command       = cmd;
        i_from_state    = from;
        i_symbol        = sym;
        i_successor_set = succ;
        i_last          = last;
        n_items++;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    task automatic send_load(input logic [nfa_pkg::STATE_W-1:0] from,
                             input logic [nfa_pkg::SYM_W-1:0] sym, input nfa_pkg::t_set succ);
        send_item(nfa_pkg::CMD_LOAD, from, sym, succ, 1'($urandom_range(0, 1)));
    endtask

    task automatic send_symbol(input logic [nfa_pkg::SYM_W-1:0] sym, input logic last);
        send_item(nfa_pkg::CMD_SYMBOL, nfa_pkg::STATE_W'($urandom()), sym, $urandom(), last);
    endtask

    task automatic send_plain(input nfa_pkg::t_cmd cmd);
        send_item(cmd, nfa_pkg::STATE_W'($urandom()), nfa_pkg::SYM_W'($urandom()), $urandom(),
                  1'($urandom_range(0, 1)));
    endtask

    // Hold input until every result is out and the block has gone quiet.
    task automatic settle();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (n_pending != 0) @(negedge i_clk);
        repeat (HOLD_OFF) @(negedge i_clk);
    endtask

    task automatic write_reg(input nfa_pkg::t_cfg_idx idx, input nfa_pkg::t_set data);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = data;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    task automatic program_regs(input logic [nfa_pkg::SYMCNT_W-1:0] sym_count,
                                input nfa_pkg::t_set init, input nfa_pkg::t_set fin,
                                input logic pol);
        write_reg(nfa_pkg::CFG_SYMBOL_COUNT, nfa_pkg::SET_W'(sym_count));
        write_reg(nfa_pkg::CFG_INITIAL_SET, init);
        write_reg(nfa_pkg::CFG_FINAL_SET, fin);
        write_reg(nfa_pkg::CFG_ACCEPT_POLARITY, nfa_pkg::SET_W'(pol));
        @(negedge i_clk);
        i_cfg_valid   = 1'b0;
        cur_sym_count = sym_count;
    endtask

    // Mostly clean symbol streams, with clears, loads and abandons mixed in.
    task automatic run_sample(input int len);
        for (int k = 0; k < len; k++) begin
            case ($urandom_range(0, 39))
                0:       send_plain(nfa_pkg::CMD_CLEAR);
                1:       send_load(pick_state(), pick_sym(), pick_set());
                2:       send_plain(nfa_pkg::CMD_EMPTY);
                default: ;
            endcase
            send_symbol(pick_sym(), k == len - 1);
        end
    endtask

    initial begin
        int unsigned phase_end;
        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;

        send_plain(nfa_pkg::CMD_EMPTY);
        settle();
        program_regs(5'd16, 32'h0000_0001, 32'h8000_0000, 1'b1);
        send_load(5'd0, 4'd0, '1);
        send_load(5'd31, 4'd15, 32'h8000_0000);
        send_load(5'd0, 4'd15, '0);
        send_symbol(4'd0, 1'b0);
        send_symbol(4'd15, 1'b1);
        send_plain(nfa_pkg::CMD_CLEAR);
        send_symbol(4'd0, 1'b0);
        send_plain(nfa_pkg::CMD_CLEAR);
        send_symbol(4'd15, 1'b1);
        send_symbol(4'd0, 1'b0);
        send_load(5'd5, 4'd3, 32'h0000_0020);
        send_symbol(4'd3, 1'b1);
        send_symbol(4'd0, 1'b0);
        send_plain(nfa_pkg::CMD_EMPTY);
        send_symbol(4'd7, 1'b0);
        send_symbol(4'd0, 1'b1);
        send_symbol(4'd0, 1'b0);
        settle();
        program_regs(5'd16, '0, 32'h0000_0001, 1'b0);
        send_symbol(4'd0, 1'b1);
        settle();
        program_regs(5'd1, '1, '1, 1'b1);
        send_symbol(4'd15, 1'b1);
        send_symbol(4'd0, 1'b1);
        send_load(5'd31, 4'd15, '1);
        send_plain(nfa_pkg::CMD_EMPTY);

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            settle();
            case (p)
                0:       program_regs(5'd1, pick_set(), pick_set(), 1'b0);
                1:       program_regs(5'd16, '1, '1, 1'b1);
                default: program_regs(nfa_pkg::SYMCNT_W'($urandom_range(1, 16)), pick_set(),
                                      pick_set(), 1'($urandom_range(0, 1)));
            endcase
            phase_end = n_items + PHASE_ITEMS;
            repeat ($urandom_range(16, 48))
                send_load(pick_state(), pick_sym(), pick_set());
            while (n_items < phase_end) begin
                if ($urandom_range(0, 9) == 0)
                    send_item(nfa_pkg::t_cmd'($urandom_range(0, 3)),
                              nfa_pkg::STATE_W'($urandom()), nfa_pkg::SYM_W'($urandom()),
                              $urandom(), 1'($urandom_range(0, 1)));
                else
                    run_sample($urandom_range(1, 6));
            end
        end

        settle();
        if (n_fails == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
